### rtl/core/u8cbo_pkg.sv
// ----------------------------------------------------------------------------
// u8cbo_pkg
// Shared types and byte codes for the UTF-8 character count to byte offset
// scanner.
// ----------------------------------------------------------------------------
package u8cbo_pkg;

  localparam int BYTE_W   = 8;
  localparam int TARGET_W = 16;
  localparam int CHARS_W  = 18;

  localparam logic [BYTE_W-1:0] TERM_BYTE   = 8'h00;
  localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'h80;
  localparam logic [BYTE_W-1:0] CONT_MASK   = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_CODE   = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD2_MASK  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD2_CODE  = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD3_MASK  = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD3_CODE  = 8'hE0;
  localparam logic [BYTE_W-1:0] TRIPLE_BYTE = 8'h85;

  localparam logic [1:0] CHARS_ONE   = 2'd1;
  localparam logic [1:0] CHARS_THREE = 2'd3;
  localparam logic [1:0] CONT_ONE    = 2'd1;
  localparam logic [1:0] CONT_TWO    = 2'd2;

  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_TRIPLE,
    CLS_BAD
  } byte_cls_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   data_byte;
    logic [TARGET_W-1:0] target_chars;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

  function automatic byte_cls_t classify(input logic [BYTE_W-1:0] b);
    byte_cls_t c;
    if (b < ASCII_LIMIT) begin
      c = CLS_ASCII;
    end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
      c = CLS_LEAD2;
    end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
      c = CLS_LEAD3;
    end else if (b == TRIPLE_BYTE) begin
      c = CLS_TRIPLE;
    end else begin
      c = CLS_BAD;
    end
    return c;
  endfunction

endpackage

### rtl/core/u8cbo_if.sv
// ----------------------------------------------------------------------------
// u8cbo_if
// Valid/ready channels for string bytes in and byte offsets out.
// ----------------------------------------------------------------------------
interface u8cbo_in_if;
  logic                            valid;
  logic                            ready;
  logic [u8cbo_pkg::BYTE_W-1:0]    data_byte;
  logic [u8cbo_pkg::TARGET_W-1:0]  target_chars;

  modport source (output valid, output data_byte, output target_chars, input ready);
  modport sink (input valid, input data_byte, input target_chars, output ready);
endinterface

interface u8cbo_out_if #(
  parameter int OFFSET_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [OFFSET_BITS-1:0] byte_offset;

  modport source (output valid, output byte_offset, input ready);
  modport sink (input valid, input byte_offset, output ready);
endinterface

### rtl/core/utf8_char_count_to_byte_offset.sv
// ----------------------------------------------------------------------------
// utf8_char_count_to_byte_offset
// Streams zero-terminated strings and reports the byte offset at which a
// character count is reached.
// ----------------------------------------------------------------------------
// Send one string byte per request, terminator included; target_chars is
// sampled from the first byte of each string. The block takes one byte every
// clock cycle unless a terminator waits on a full result register, and presents
// one byte_offset for each terminator through the input register and the
// result register. That rate is set by the scan stage, which updates the
// character count and stop offset for one byte per step between the input
// register and the result register. Offsets saturate at 2^OFFSET_BITS - 1.
// ----------------------------------------------------------------------------
module utf8_char_count_to_byte_offset #(
  parameter int OFFSET_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  u8cbo_in_if.sink      in_req,
  u8cbo_out_if.source   out_res
);

  u8cbo_pkg::stage_t       stg;
  logic                    advance;
  logic                    is_term;
  logic                    out_stall;
  logic [OFFSET_BITS-1:0]  res_offset;

  assign advance = stg.valid && (!is_term || !out_stall);

  u8cbo_in_reg u_in_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .advance (advance),
    .stg     (stg)
  );

  u8cbo_scan #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .item       (stg.item),
    .is_term    (is_term),
    .res_offset (res_offset)
  );

  u8cbo_out_reg #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_out_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (advance && is_term),
    .data    (res_offset),
    .stall   (out_stall),
    .out_res (out_res)
  );

endmodule

### rtl/core/u8cbo_in_reg.sv
// ----------------------------------------------------------------------------
// u8cbo_in_reg
// Input register: captures one request and holds it until the scan advances.
// ----------------------------------------------------------------------------
module u8cbo_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  u8cbo_in_if.sink           in_req,
  input  logic               advance,
  output u8cbo_pkg::stage_t  stg
);

  logic              valid_r;
  u8cbo_pkg::item_t  item_r;
  logic              load;

  assign in_req.ready = !valid_r || advance;
  assign load         = in_req.valid && in_req.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.data_byte    <= in_req.data_byte;
      item_r.target_chars <= in_req.target_chars;
    end
  end

  assign stg.valid = valid_r;
  assign stg.item  = item_r;

endmodule

### rtl/core/u8cbo_scan.sv
// ----------------------------------------------------------------------------
// u8cbo_scan
// Per-string walk state: decodes one byte per step, counts characters and
// tracks where the walk stops.
// ----------------------------------------------------------------------------
module u8cbo_scan #(
  parameter int OFFSET_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step,
  input  u8cbo_pkg::item_t        item,
  output logic                    is_term,
  output logic [OFFSET_BITS-1:0]  res_offset
);

  logic [OFFSET_BITS-1:0]          pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0]          stop_r, stop_nxt;
  logic [u8cbo_pkg::CHARS_W-1:0]   chars_r, chars_nxt;
  logic [u8cbo_pkg::TARGET_W-1:0]  tgt_r, tgt_nxt;
  logic [1:0]                      pend_r, pend_nxt;
  logic                            done_r, done_nxt;
  logic                            start_r, start_nxt;

  logic [OFFSET_BITS-1:0]          pos_inc;
  logic [u8cbo_pkg::CHARS_W:0]     sum_one;
  logic [u8cbo_pkg::CHARS_W:0]     sum_three;
  logic [u8cbo_pkg::CHARS_W-1:0]   chars_one;
  logic [u8cbo_pkg::CHARS_W-1:0]   chars_three;
  logic [u8cbo_pkg::BYTE_W-1:0]    b;
  u8cbo_pkg::byte_cls_t            cls;

  assign b          = item.data_byte;
  assign cls        = u8cbo_pkg::classify(b);
  assign is_term    = (b == u8cbo_pkg::TERM_BYTE);
  assign res_offset = (done_r || pend_r != 2'd0) ? stop_r : pos_r;
  assign pos_inc    = (&pos_r) ? pos_r : pos_r + OFFSET_BITS'(1);
  assign tgt_nxt    = start_r ? item.target_chars : tgt_r;

  assign sum_one     = {1'b0, chars_r} + (u8cbo_pkg::CHARS_W + 1)'(u8cbo_pkg::CHARS_ONE);
  assign sum_three   = {1'b0, chars_r} + (u8cbo_pkg::CHARS_W + 1)'(u8cbo_pkg::CHARS_THREE);
  assign chars_one   = sum_one[u8cbo_pkg::CHARS_W] ? {u8cbo_pkg::CHARS_W{1'b1}}
                                                   : sum_one[u8cbo_pkg::CHARS_W-1:0];
  assign chars_three = sum_three[u8cbo_pkg::CHARS_W] ? {u8cbo_pkg::CHARS_W{1'b1}}
                                                     : sum_three[u8cbo_pkg::CHARS_W-1:0];

  always_comb begin
    pos_nxt   = pos_inc;
    stop_nxt  = stop_r;
    chars_nxt = chars_r;
    pend_nxt  = pend_r;
    done_nxt  = done_r;
    start_nxt = 1'b0;
    if (is_term) begin
      pos_nxt   = '0;
      stop_nxt  = '0;
      chars_nxt = '0;
      pend_nxt  = 2'd0;
      done_nxt  = 1'b0;
      start_nxt = 1'b1;
    end else if (!done_r) begin
      if (pend_r != 2'd0) begin
        if ((b & u8cbo_pkg::CONT_MASK) == u8cbo_pkg::CONT_CODE) begin
          pend_nxt = pend_r - 2'd1;
          if (pend_r == u8cbo_pkg::CONT_ONE) begin
            chars_nxt = chars_one;
          end
        end else begin
          pend_nxt = 2'd0;
          done_nxt = 1'b1;
        end
      end else if (chars_r >= u8cbo_pkg::CHARS_W'(tgt_nxt)) begin
        stop_nxt = pos_r;
        done_nxt = 1'b1;
      end else begin
        case (cls)
          u8cbo_pkg::CLS_ASCII: begin
            chars_nxt = chars_one;
          end
          u8cbo_pkg::CLS_LEAD2: begin
            stop_nxt = pos_r;
            pend_nxt = u8cbo_pkg::CONT_ONE;
          end
          u8cbo_pkg::CLS_LEAD3: begin
            stop_nxt = pos_r;
            pend_nxt = u8cbo_pkg::CONT_TWO;
          end
          u8cbo_pkg::CLS_TRIPLE: begin
            chars_nxt = chars_three;
          end
          default: begin
            stop_nxt = pos_inc;
            done_nxt = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      stop_r  <= '0;
      chars_r <= '0;
      tgt_r   <= '0;
      pend_r  <= 2'd0;
      done_r  <= 1'b0;
      start_r <= 1'b1;
    end else if (step) begin
      pos_r   <= pos_nxt;
      stop_r  <= stop_nxt;
      chars_r <= chars_nxt;
      tgt_r   <= tgt_nxt;
      pend_r  <= pend_nxt;
      done_r  <= done_nxt;
      start_r <= start_nxt;
    end
  end

endmodule

### rtl/core/u8cbo_out_reg.sv
// ----------------------------------------------------------------------------
// u8cbo_out_reg
// Result register: holds one byte offset until the downstream side takes it.
// ----------------------------------------------------------------------------
module u8cbo_out_reg #(
  parameter int OFFSET_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    load,
  input  logic [OFFSET_BITS-1:0]  data,
  output logic                    stall,
  u8cbo_out_if.source             out_res
);

  logic                   valid_r;
  logic [OFFSET_BITS-1:0] off_r;

  assign stall               = valid_r && !out_res.ready;
  assign out_res.valid       = valid_r;
  assign out_res.byte_offset = off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_res.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      off_r <= data;
    end
  end

endmodule

### rtl/core/u8cbo_checker.sv
// ----------------------------------------------------------------------------
// u8cbo_checker
// Port-level checks: results follow terminators and the pipeline stays
// within its two slots.
// ----------------------------------------------------------------------------
module u8cbo_checker #(
  parameter int OFFSET_BITS = 16
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic [7:0]              in_data_byte,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [OFFSET_BITS-1:0]  out_byte_offset
);

  logic [2:0] owed_r;
  logic       term_acc;
  logic       res_acc;

  assign term_acc = in_valid && in_ready && (in_data_byte == u8cbo_pkg::TERM_BYTE);
  assign res_acc  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owed_r <= 3'd0;
    end else begin
      owed_r <= owed_r + 3'(term_acc) - 3'(res_acc);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte_offset))
    else $error("result dropped or changed while stalled");

  a_owed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> owed_r != 3'd0)
    else $error("result without an accepted terminator");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    owed_r <= 3'd2)
    else $error("more than two terminators in flight");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    owed_r == 3'd2 && !out_ready |-> !in_ready)
    else $error("request taken while both slots hold terminators");

endmodule

bind utf8_char_count_to_byte_offset u8cbo_checker #(
  .OFFSET_BITS (OFFSET_BITS)
) u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_req.valid),
  .in_ready        (in_req.ready),
  .in_data_byte    (in_req.data_byte),
  .out_valid       (out_res.valid),
  .out_ready       (out_res.ready),
  .out_byte_offset (out_res.byte_offset)
);

### tb/sv/tb_utf8_char_count_to_byte_offset.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_char_count_to_byte_offset
// Streams zero-terminated byte strings into the scanner and checks every
// reported byte offset against a cycle-free prediction of the character walk.
// Directed strings cover each byte class and stop rule. A long output stall
// backs the block up. Random well-formed, broken and noise strings then run
// with bursty idling on both channels, and finally back to back without idling.
// ----------------------------------------------------------------------------
module tb_utf8_char_count_to_byte_offset;

  localparam int OFFSET_BITS    = 16;
  localparam int CLK_HALF       = 5;
  localparam int LONG_HOLD      = 600;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES    = 20;
  localparam logic [17:0] CHARS_CAP = 18'h3FFFF;

  typedef struct {
    logic [OFFSET_BITS-1:0]         pos;
    logic [OFFSET_BITS-1:0]         stop;
    logic [17:0]                    chars;
    logic [u8cbo_pkg::TARGET_W-1:0] target;
    logic [1:0]                     pend;
    bit                             done;
    bit                             at_start;
  } scan_state_t;

  logic clk;
  logic rst_n;

  u8cbo_in_if                              in_req_if();
  u8cbo_out_if #(.OFFSET_BITS(OFFSET_BITS)) out_res_if();

  utf8_char_count_to_byte_offset #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req_if),
    .out_res (out_res_if)
  );

  scan_state_t                  scan;
  logic [OFFSET_BITS-1:0]       pending_offsets[$];
  logic [u8cbo_pkg::BYTE_W-1:0] str_q[$];

  int  mismatches;
  int  offsets_checked;
  int  bytes_sent;
  int  strings_sent;
  int  quiet_cycles;
  bit  tx_idle_en;
  bit  rx_idle_en;
  bit  long_hold_go;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic logic [OFFSET_BITS-1:0] offset_step(input logic [OFFSET_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [17:0] chars_plus(input logic [17:0] c, input int unsigned n);
    logic [18:0] sum;
    sum = {1'b0, c} + 19'(n);
    return (sum > {1'b0, CHARS_CAP}) ? CHARS_CAP : sum[17:0];
  endfunction

  function automatic void scan_restart();
    scan.pos      = '0;
    scan.stop     = '0;
    scan.chars    = '0;
    scan.pend     = '0;
    scan.done     = 1'b0;
    scan.at_start = 1'b1;
  endfunction

  // Walk one accepted byte; a terminator yields the expected offset.
  function automatic void predict_scan_step(input logic [u8cbo_pkg::BYTE_W-1:0] b,
                                            input logic [u8cbo_pkg::TARGET_W-1:0] t);
    logic [OFFSET_BITS-1:0] res;
    if (scan.at_start) begin
      scan.target   = t;
      scan.at_start = 1'b0;
    end
    if (b == u8cbo_pkg::TERM_BYTE) begin
      res = (scan.done || scan.pend != 0) ? scan.stop : scan.pos;
      pending_offsets.push_back(res);
      scan_restart();
      return;
    end
    if (!scan.done) begin
      if (scan.pend != 0) begin
        if ((b & u8cbo_pkg::CONT_MASK) == u8cbo_pkg::CONT_CODE) begin
          scan.pend = scan.pend - 1'b1;
          if (scan.pend == 0) scan.chars = chars_plus(scan.chars, 1);
        end else begin
          scan.pend = '0;
          scan.done = 1'b1;
        end
      end else if (scan.chars >= {2'b00, scan.target}) begin
        scan.stop = scan.pos;
        scan.done = 1'b1;
      end else if (b < u8cbo_pkg::ASCII_LIMIT) begin
        scan.chars = chars_plus(scan.chars, 1);
      end else if ((b & u8cbo_pkg::LEAD2_MASK) == u8cbo_pkg::LEAD2_CODE) begin
        scan.stop = scan.pos;
        scan.pend = u8cbo_pkg::CONT_ONE;
      end else if ((b & u8cbo_pkg::LEAD3_MASK) == u8cbo_pkg::LEAD3_CODE) begin
        scan.stop = scan.pos;
        scan.pend = u8cbo_pkg::CONT_TWO;
      end else if (b == u8cbo_pkg::TRIPLE_BYTE) begin
        scan.chars = chars_plus(scan.chars, 3);
      end else begin
        scan.stop = offset_step(scan.pos);
        scan.done = 1'b1;
      end
    end
    scan.pos = offset_step(scan.pos);
  endfunction

  task automatic send_byte(input logic [u8cbo_pkg::BYTE_W-1:0] b,
                           input logic [u8cbo_pkg::TARGET_W-1:0] t);
    in_req_if.valid        <= 1'b1;
    in_req_if.data_byte    <= b;
    in_req_if.target_chars <= t;
    @(posedge clk);
    while (!in_req_if.ready) @(posedge clk);
    predict_scan_step(b, t);
    bytes_sent++;
    if (tx_idle_en && $urandom_range(0, 7) == 0) begin
      in_req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // Send str_q followed by its terminator; only the first byte carries the target.
  task automatic send_string(input logic [u8cbo_pkg::TARGET_W-1:0] target);
    foreach (str_q[i])
      send_byte(str_q[i], (i == 0) ? target : u8cbo_pkg::TARGET_W'($urandom));
    send_byte(u8cbo_pkg::TERM_BYTE,
              (str_q.size() == 0) ? target : u8cbo_pkg::TARGET_W'($urandom));
    strings_sent++;
  endtask

  task automatic wait_drain();
    in_req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_offsets.size() != 0) @(posedge clk);
  endtask

  function automatic void build_text(input bit noise, input bit broken, output int n_chars);
    int len;
    int k;
    int idx;
    str_q.delete();
    n_chars = 0;
    len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
    for (int i = 0; i < len; i++) begin
      k = noise ? 10 : $urandom_range(0, 9);
      case (k)
        5, 6: begin
          str_q.push_back(u8cbo_pkg::LEAD2_CODE | u8cbo_pkg::BYTE_W'($urandom_range(0, 31)));
          str_q.push_back(u8cbo_pkg::CONT_CODE | u8cbo_pkg::BYTE_W'($urandom_range(0, 63)));
          n_chars += 1;
        end
        7: begin
          str_q.push_back(u8cbo_pkg::LEAD3_CODE | u8cbo_pkg::BYTE_W'($urandom_range(0, 15)));
          str_q.push_back(u8cbo_pkg::CONT_CODE | u8cbo_pkg::BYTE_W'($urandom_range(0, 63)));
          str_q.push_back(u8cbo_pkg::CONT_CODE | u8cbo_pkg::BYTE_W'($urandom_range(0, 63)));
          n_chars += 1;
        end
        8: begin
          str_q.push_back(u8cbo_pkg::TRIPLE_BYTE);
          n_chars += 3;
        end
        10: begin
          str_q.push_back(u8cbo_pkg::BYTE_W'($urandom_range(1, 255)));
          n_chars += 1;
        end
        default: begin
          str_q.push_back(u8cbo_pkg::BYTE_W'($urandom_range(1, 127)));
          n_chars += 1;
        end
      endcase
    end
    if (broken && str_q.size() != 0) begin
      if ($urandom_range(0, 1) == 0) begin
        void'(str_q.pop_back());
      end else begin
        idx = $urandom_range(0, str_q.size() - 1);
        str_q[idx] = u8cbo_pkg::BYTE_W'($urandom_range(1, 255));
      end
    end
  endfunction

  task automatic send_random_strings(input int n_bytes);
    int stop_at;
    int n_chars;
    int mode;
    int sel;
    logic [u8cbo_pkg::TARGET_W-1:0] target;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      mode = $urandom_range(0, 9);
      build_text(mode == 0, mode == 1, n_chars);
      sel = $urandom_range(0, 9);
      if (sel == 0)      target = '0;
      else if (sel == 1) target = u8cbo_pkg::TARGET_W'($urandom);
      else               target = u8cbo_pkg::TARGET_W'($urandom_range(0, n_chars + 1));
      send_string(target);
    end
  endtask

  task automatic test_empty_and_zero_target();
    str_q.delete();
    send_string(16'd5);
    str_q = '{8'h41};
    send_string(16'd0);
    str_q = '{u8cbo_pkg::TRIPLE_BYTE};
    send_string(16'd0);
    wait_drain();
  endtask

  task automatic test_char_classes();
    str_q = '{8'h7F, 8'h01, 8'hC3, 8'hA9};
    send_string(16'd2);
    str_q = '{8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'h41};
    send_string(16'd2);
    str_q = '{u8cbo_pkg::TRIPLE_BYTE, 8'h41};
    send_string(16'd2);
    wait_drain();
  endtask

  task automatic test_scan_stops();
    str_q = '{8'hDF, 8'h41};
    send_string(16'd3);
    str_q = '{8'h41, 8'hEF, 8'hBF};
    send_string(16'd3);
    str_q = '{8'h41, 8'h80};
    send_string(16'd9);
    str_q = '{8'hBF};
    send_string(16'd9);
    str_q = '{8'hF0};
    send_string(16'd9);
    str_q = '{8'hFF};
    send_string(16'd9);
    str_q = '{8'h41, 8'h42};
    send_string(16'hFFFF);
    wait_drain();
  endtask

  task automatic test_output_backpressure();
    bit saved_idle;
    saved_idle   = tx_idle_en;
    tx_idle_en   = 1'b0;
    long_hold_go = 1'b1;
    for (int i = 0; i < 40; i++) begin
      str_q = '{u8cbo_pkg::BYTE_W'($urandom_range(1, 255))};
      send_string(u8cbo_pkg::TARGET_W'($urandom_range(0, 2)));
    end
    tx_idle_en = saved_idle;
    wait_drain();
  endtask

  task automatic test_random_strings();
    for (int chunk = 0; chunk < 9; chunk++) begin
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      send_random_strings(150);
    end
    wait_drain();
  endtask

  task automatic test_back_to_back();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_random_strings(200);
    wait_drain();
  endtask

  // Receiver: random stall bursts, plus one long hold on request.
  initial begin
    out_res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_go) begin
        long_hold_go = 1'b0;
        out_res_if.ready <= 1'b0;
        for (int n = 0; n < LONG_HOLD; n++) @(posedge clk);
        out_res_if.ready <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        out_res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_res_if.ready <= 1'b1;
      end else begin
        out_res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    logic [OFFSET_BITS-1:0] want;
    if (rst_n && out_res_if.valid && out_res_if.ready) begin
      if (pending_offsets.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: byte_offset %0d returned with no string pending",
                   out_res_if.byte_offset);
      end else begin
        want = pending_offsets.pop_front();
        offsets_checked++;
        if (out_res_if.byte_offset !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: byte_offset mismatch, expected %0d, got %0d",
                     want, out_res_if.byte_offset);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_req_if.valid && in_req_if.ready) || (out_res_if.valid && out_res_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR: no request moved for %0d cycles", quiet_cycles);
      $display("** utf8_char_count_to_byte_offset: FAILED **");
      $finish;
    end
  end

  initial begin
    mismatches      = 0;
    offsets_checked = 0;
    bytes_sent      = 0;
    strings_sent    = 0;
    quiet_cycles    = 0;
    tx_idle_en      = 1'b1;
    rx_idle_en      = 1'b1;
    long_hold_go    = 1'b0;
    scan_restart();
    scan.target = '0;
    rst_n                  <= 1'b0;
    in_req_if.valid        <= 1'b0;
    in_req_if.data_byte    <= '0;
    in_req_if.target_chars <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_and_zero_target();
    test_char_classes();
    test_scan_stops();
    test_output_backpressure();
    test_random_strings();
    test_back_to_back();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_offsets.size() != 0) begin
      $display("ERROR: %0d byte offsets never returned", pending_offsets.size());
      mismatches += pending_offsets.size();
    end
    $display("Run covered %0d bytes in %0d strings, %0d offsets compared, %0d mismatches.",
             bytes_sent, strings_sent, offsets_checked, mismatches);
    $display("Included every byte class, each stop rule, random text and a long stall.");
    if (mismatches == 0) begin
      $display("** utf8_char_count_to_byte_offset: PASSED **");
    end else begin
      $display("** utf8_char_count_to_byte_offset: FAILED **");
    end
    $finish;
  end

endmodule
